[hw/rtl/assert_macros.svh]
// assertion helpers for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define C2U_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("c2u assertion failed");

// checked on every edge, reset included
`define C2U_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("c2u assertion failed");

`endif

[hw/rtl/c2u_pkg.sv]
package c2u_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [15:0] LetterBase  = 16'h05D0;
  localparam logic [15:0] PointBase   = 16'h05B0;
  localparam logic [15:0] Replacement = 16'hFFFD;
  localparam logic [15:0] TwoByteMin  = 16'h0080;
  localparam logic [15:0] ThreeByteMin = 16'h0800;

  localparam logic [1:0] NumOne   = 2'd1;
  localparam logic [1:0] NumTwo   = 2'd2;
  localparam logic [1:0] NumThree = 2'd3;

  // one character, already encoded
  typedef struct packed {
    logic [1:0] nbytes;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } c2u_enc_t;

  function automatic logic [15:0] to_code_point(input logic [7:0] b);
    logic [15:0] cp;
    cp = Replacement;
    if (b < 8'h80) begin
      cp = {8'h00, b};
    end else if (b >= 8'hE0 && b <= 8'hFA) begin
      cp = LetterBase + {8'h00, b - 8'hE0};
    end else if (b >= 8'hC0 && b <= 8'hD1) begin
      cp = PointBase + {8'h00, b - 8'hC0};
    end else begin
      unique case (b)
        8'hA0:   cp = 16'h00A0;
        8'hA4:   cp = 16'h20AA;
        8'hD3:   cp = 16'h05F3;
        8'hD4:   cp = 16'h05F4;
        8'hD7:   cp = 16'h05F0;
        8'hD8:   cp = 16'h05F1;
        8'h96:   cp = 16'h2013;
        8'h97:   cp = 16'h2014;
        8'h91:   cp = 16'h2018;
        8'h92:   cp = 16'h2019;
        8'h93:   cp = 16'h201C;
        8'h94:   cp = 16'h201D;
        8'h85:   cp = 16'h2026;
        default: cp = Replacement;
      endcase
    end
    return cp;
  endfunction

  function automatic c2u_enc_t encode(input logic [15:0] cp);
    c2u_enc_t e;
    e = '0;
    if (cp < TwoByteMin) begin
      e.nbytes = NumOne;
      e.b0     = cp[7:0];
    end else if (cp < ThreeByteMin) begin
      e.nbytes = NumTwo;
      e.b0     = {3'b110, cp[10:6]};
      e.b1     = {2'b10, cp[5:0]};
    end else begin
      e.nbytes = NumThree;
      e.b0     = {4'b1110, cp[15:12]};
      e.b1     = {2'b10, cp[11:6]};
      e.b2     = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

[hw/rtl/c2u_front.sv]
module c2u_front
  import c2u_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       enc_valid,
  input  logic       enc_ready,
  output c2u_enc_t   enc
);

  logic     vld_r, vld_nxt;
  c2u_enc_t enc_r;

  assign in_ready  = !vld_r || enc_ready;
  assign enc_valid = vld_r;
  assign enc       = enc_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      enc_r <= encode(to_code_point(in_byte));
    end
  end

endmodule

[hw/rtl/c2u_queue.sv]
module c2u_queue
  import c2u_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  c2u_enc_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output c2u_enc_t rd_data
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  c2u_enc_t            mem_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                do_wr, do_rd;

  assign wr_ready = cnt_r != CntW'(Depth);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[hw/rtl/c2u_back.sv]
module c2u_back
  import c2u_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       enc_valid,
  output logic       enc_ready,
  input  c2u_enc_t   enc,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  c2u_enc_t   cur_r;
  logic       vld_r, vld_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       fire;

  assign out_valid = vld_r;
  assign out_last  = idx_r == (cur_r.nbytes - 1'b1);
  assign fire      = vld_r && out_ready;
  assign enc_ready = !vld_r || (fire && out_last);

  always_comb begin
    unique case (idx_r)
      2'd0:    out_byte = cur_r.b0;
      2'd1:    out_byte = cur_r.b1;
      default: out_byte = cur_r.b2;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (enc_ready) begin
      vld_nxt = enc_valid;
      idx_nxt = '0;
    end else if (fire) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enc_ready && enc_valid) begin
      cur_r <= enc;
    end
  end

endmodule

[hw/rtl/cp1255_to_utf8_transcoder_core.sv]
// path: an input byte passes the classify register, a queue entry and the output
// register before the first utf-8 byte of its character is transferred
// throughput: one output byte per cycle while out_tready is high, so the input rate
// follows each character's utf-8 length (1 to 3 bytes); the output serializer sets it
// reset: synchronous active-low rst_n empties the pipeline and the queue
module cp1255_to_utf8_transcoder_core
  import c2u_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] code_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] utf8_byte
  output logic       out_tlast   // last_of_char
);

  c2u_enc_t front_enc, queue_enc;
  logic     front_valid, front_ready;
  logic     queue_valid, queue_ready;

  c2u_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .enc_valid (front_valid),
    .enc_ready (front_ready),
    .enc       (front_enc)
  );

  c2u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_enc),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_data  (queue_enc)
  );

  c2u_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .enc_valid (queue_valid),
    .enc_ready (queue_ready),
    .enc       (queue_enc),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

[hw/rtl/c2u_checker.sv]
`include "assert_macros.svh"

module c2u_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // stalled output holds
  `C2U_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))

  // a non-final byte is followed at once by a continuation byte
  `C2U_ASSERT(a_cont_next, clk, rst_n, (out_tvalid && out_tready && !out_tlast) |=> (out_tvalid && out_tdata[7:6] == 2'b10))

  // ascii and three-byte leads are final and non-final
  `C2U_ASSERT(a_ascii_last, clk, rst_n, (out_tvalid && !out_tdata[7]) |-> out_tlast)
  `C2U_ASSERT(a_lead3_not_last, clk, rst_n, (out_tvalid && out_tdata[7:5] == 3'b111) |-> !out_tlast)

  // nothing shown right after reset
  `C2U_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid)

endmodule

bind cp1255_to_utf8_transcoder_core c2u_checker u_c2u_checker (.*);
